// ----- hw/rtl/irpd_pkg.sv -----
// ----------------------------------------------------------------------------
// irpd_pkg
// Types, constants and lookup functions shared by the IR pulse decoder and
// its multi-tap keypad logic.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int IN_W      = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_N     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_KEYS  = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HI   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_END_HI   = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_N] = '{
        24'd400000, 24'd410000, 24'd80000, 24'd100000,
        24'd170000, 24'd190000, 24'd4100000, 24'd4120000
    };

    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_ENTER      = 4'd10;
    localparam logic [3:0] KEY_MUTE       = 4'd11;
    localparam logic [3:0] KEY_UNKNOWN    = 4'd12;

    localparam logic [1:0] SHOW_NONE    = 2'd0;
    localparam logic [1:0] SHOW_NEW     = 2'd1;
    localparam logic [1:0] SHOW_REPLACE = 2'd2;

    localparam logic [31:0] KEY_CODES [NUM_KEYS] = '{
        32'd10045623, 32'd10063983, 32'd10074183, 32'd10090503,
        32'd10072143, 32'd10066023, 32'd10082343, 32'd10061943,
        32'd10070103, 32'd10086423, 32'd10031343, 32'd10051743
    };

    typedef struct packed {
        logic [IN_W-1:0] interval;
    } t_in_item;

    typedef struct packed {
        logic [31:0] frame_code;
        logic [3:0]  key;
        logic        commit_valid;
        logic [7:0]  commit_char;
        logic [1:0]  show_action;
        logic [7:0]  show_char;
        logic        erase_last;
        logic        send_message;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [3:0] key;
        logic [2:0] tap;
    } t_tap_state;

    function automatic logic in_window(logic [IN_W-1:0] v, logic [CFG_W-1:0] lo,
                                       logic [CFG_W-1:0] hi);
        return (IN_W'(lo) < v) && (v < IN_W'(hi));
    endfunction

    function automatic logic [3:0] key_lookup(logic [31:0] code);
        logic [3:0] k;
        k = KEY_UNKNOWN;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (code == KEY_CODES[i]) begin
                k = 4'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [2:0] tap_cycle(logic [3:0] k);
        case (k)
            4'd0:    return 3'd2;
            4'd1:    return 3'd1;
            4'd7:    return 3'd5;
            4'd9:    return 3'd5;
            default: return 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] letter_at(logic [3:0] k, logic [2:0] t);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            4'd0: case (t)
                3'd0: c = " ";  3'd1: c = "0";
                default: c = 8'h00;
            endcase
            4'd1: case (t)
                3'd0: c = "1";
                default: c = 8'h00;
            endcase
            4'd2: case (t)
                3'd0: c = "a";  3'd1: c = "b";  3'd2: c = "c";  3'd3: c = "2";
                default: c = 8'h00;
            endcase
            4'd3: case (t)
                3'd0: c = "d";  3'd1: c = "e";  3'd2: c = "f";  3'd3: c = "3";
                default: c = 8'h00;
            endcase
            4'd4: case (t)
                3'd0: c = "g";  3'd1: c = "h";  3'd2: c = "i";  3'd3: c = "4";
                default: c = 8'h00;
            endcase
            4'd5: case (t)
                3'd0: c = "j";  3'd1: c = "k";  3'd2: c = "l";  3'd3: c = "5";
                default: c = 8'h00;
            endcase
            4'd6: case (t)
                3'd0: c = "m";  3'd1: c = "n";  3'd2: c = "o";  3'd3: c = "6";
                default: c = 8'h00;
            endcase
            4'd7: case (t)
                3'd0: c = "p";  3'd1: c = "q";  3'd2: c = "r";  3'd3: c = "s";
                3'd4: c = "7";
                default: c = 8'h00;
            endcase
            4'd8: case (t)
                3'd0: c = "t";  3'd1: c = "u";  3'd2: c = "v";  3'd3: c = "8";
                default: c = 8'h00;
            endcase
            4'd9: case (t)
                3'd0: c = "w";  3'd1: c = "x";  3'd2: c = "y";  3'd3: c = "z";
                3'd4: c = "9";
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/irpd_in_if.sv -----
// ----------------------------------------------------------------------------
// irpd_in_if
// Valid/ready channel carrying one edge interval request.
// ----------------------------------------------------------------------------
interface irpd_in_if import irpd_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ----- hw/rtl/irpd_out_if.sv -----
// ----------------------------------------------------------------------------
// irpd_out_if
// Valid/ready channel carrying one decoded key event request.
// ----------------------------------------------------------------------------
interface irpd_out_if import irpd_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ----- hw/rtl/irpd_keypad.sv -----
// ----------------------------------------------------------------------------
// irpd_keypad
// Key code match and multi-tap text entry: builds one event from a finished
// frame code and the pending tap, and gives the next pending tap.
// ----------------------------------------------------------------------------
module irpd_keypad import irpd_pkg::*; (
    input  logic [31:0] i_code,
    input  t_tap_state  i_tap,
    output t_tap_state  o_tap,
    output t_out_item   o_res
);

    logic [3:0] key;
    logic [2:0] cyc;
    logic [3:0] tap_inc;

    always_comb begin
        key     = key_lookup(i_code);
        cyc     = tap_cycle(key);
        tap_inc = {1'b0, i_tap.tap} + 4'd1;

        o_tap = i_tap;
        o_res = '0;
        o_res.frame_code = i_code;
        o_res.key        = key;

        if (key <= KEY_LAST_DIGIT) begin
            if (i_tap.valid && i_tap.key == key) begin
                o_tap.tap = (tap_inc >= {1'b0, cyc}) ? 3'd0 : tap_inc[2:0];
                o_res.show_action = SHOW_REPLACE;
            end else begin
                if (i_tap.valid) begin
                    o_res.commit_valid = 1'b1;
                    o_res.commit_char  = letter_at(i_tap.key, i_tap.tap);
                end
                o_tap.valid = 1'b1;
                o_tap.key   = key;
                o_tap.tap   = 3'd0;
                o_res.show_action = SHOW_NEW;
            end
            o_res.show_char = letter_at(o_tap.key, o_tap.tap);
        end else if (key == KEY_ENTER) begin
            if (i_tap.valid) begin
                o_res.commit_valid = 1'b1;
                o_res.commit_char  = letter_at(i_tap.key, i_tap.tap);
                o_tap.valid        = 1'b0;
            end else begin
                o_res.send_message = 1'b1;
            end
        end else if (key == KEY_MUTE) begin
            o_res.erase_last = 1'b1;
        end
    end

endmodule

// ----- hw/rtl/ir_pulse_decoder_multitap.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_decoder_multitap
// IR pulse interval decoder with key matching and multi-tap text entry.
// An accepted interval is registered first; an end interval then registers its key event for the output.
// Throughput: one interval per cycle; limited only by output backpressure.
// Reset (sync, active low): thresholds reload, code, bit count and pending
// tap clear, both pipeline registers empty.
// ----------------------------------------------------------------------------
module ir_pulse_decoder_multitap import irpd_pkg::*; #(
    parameter int CODE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    irpd_in_if.sink              i_in,
    irpd_out_if.source           o_out
);

    localparam int CNT_W = $clog2(CODE_BITS + 1);

    logic [CFG_W-1:0]     r_cfg [CFG_N];
    logic                 r_in_vld;
    logic [IN_W-1:0]      r_interval;
    logic [CODE_BITS-1:0] r_code, n_code;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    t_tap_state           r_tap, n_tap;
    logic                 r_out_vld;
    t_out_item            r_out;

    logic                 is_start, is_zero, is_one, is_end;
    logic [CNT_W-1:0]     bit_pos;
    logic                 advance;
    t_tap_state           kp_tap;
    t_out_item            kp_res;

    irpd_keypad u_keypad (
        .i_code (32'(r_code)),
        .i_tap  (r_tap),
        .o_tap  (kp_tap),
        .o_res  (kp_res)
    );

    always_comb begin
        is_start = in_window(r_interval, r_cfg[CFG_START_LO], r_cfg[CFG_START_HI]);
        is_zero  = in_window(r_interval, r_cfg[CFG_ZERO_LO], r_cfg[CFG_ZERO_HI]);
        is_one   = in_window(r_interval, r_cfg[CFG_ONE_LO], r_cfg[CFG_ONE_HI]);
        is_end   = in_window(r_interval, r_cfg[CFG_END_LO], r_cfg[CFG_END_HI]);
        bit_pos  = CNT_W'(CODE_BITS - 1) - r_cnt;

        n_code = r_code;
        n_cnt  = r_cnt;
        n_tap  = r_tap;

        if (is_start) begin
            n_code = '0;
            n_cnt  = '0;
        end else if (is_zero || is_one) begin
            if (r_cnt < CNT_W'(CODE_BITS)) begin
                for (int i = 0; i < CODE_BITS; i++) begin
                    if (!is_zero && CNT_W'(i) == bit_pos) begin
                        n_code[i] = 1'b1;
                    end
                end
                n_cnt = r_cnt + CNT_W'(1);
            end
        end else if (is_end) begin
            n_tap = kp_tap;
        end

        advance = r_in_vld && (!is_end || is_start || is_zero || is_one ||
                               !r_out_vld || o_out.ready);
    end

    assign i_in.ready  = !r_in_vld || advance;
    assign o_out.valid = r_out_vld;
    assign o_out.req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_interval <= i_in.req.interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
            r_cnt  <= '0;
            r_tap  <= '0;
        end else if (advance) begin
            r_code <= n_code;
            r_cnt  <= n_cnt;
            r_tap  <= n_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && is_end && !is_start && !is_zero && !is_one) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_end && !is_start && !is_zero && !is_one) begin
            r_out <= kp_res;
        end
    end

endmodule

// ----- hw/rtl/irpd_checker.sv -----
// ----------------------------------------------------------------------------
// irpd_checker
// Port-level checks on the decoder's event channel, bound to the top level.
// ----------------------------------------------------------------------------
module irpd_checker import irpd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      i_ready,
    input t_out_item i_res
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_res))
        else $error("event changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("event valid right after reset");

    a_digit_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_res.key <= KEY_LAST_DIGIT |->
            (i_res.show_action == SHOW_NEW || i_res.show_action == SHOW_REPLACE) &&
            i_res.show_char != 8'h00 && !i_res.erase_last && !i_res.send_message)
        else $error("digit event without a shown letter");

    a_other_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_res.key > KEY_LAST_DIGIT |->
            i_res.show_action == SHOW_NONE && i_res.show_char == 8'h00 &&
            (i_res.erase_last == (i_res.key == KEY_MUTE)) &&
            (i_res.key == KEY_ENTER || (!i_res.commit_valid && !i_res.send_message)))
        else $error("non-digit event with wrong actions");

    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_res.commit_valid ? (i_res.commit_char != 8'h00 &&
            !i_res.send_message) : i_res.commit_char == 8'h00))
        else $error("commit letter inconsistent");

endmodule

bind ir_pulse_decoder_multitap irpd_checker u_irpd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_res   (o_out.req)
);

// ----- tb/ir_pulse_decoder_multitap_test.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_decoder_multitap_test
// Streams edge intervals into the IR decoder, mostly as whole frames that
// carry key codes, mixed with noise, short and overlong frames. Threshold
// registers change between phases: reset values, the tightest and highest
// windows, all-zero and all-ones settings, and random ones. A local model
// of the decoder and the multi-tap keypad predicts each key event, and the
// observed events are compared field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module ir_pulse_decoder_multitap_test;
    import irpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_BITS    = 32;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_LEN     = 400;
    localparam int CALM_START   = 1500;
    localparam int CALM_END     = 2300;

    localparam int W_START = 0;
    localparam int W_ZERO  = 1;
    localparam int W_ONE   = 2;
    localparam int W_END   = 3;

    typedef logic [CFG_N-1:0][CFG_W-1:0] t_th_set;

    localparam logic [IN_W-1:0] EDGE_CASES [20] = '{
        32'd4100001, 32'd0, 32'hFFFF_FFFF, 32'd400000, 32'd410000,
        32'd80000, 32'd100000, 32'd170000, 32'd190000, 32'd4100000,
        32'd4120000, 32'h00FF_FFFF, 32'h0100_0000, 32'd400001, 32'd409999,
        32'd80001, 32'd99999, 32'd170001, 32'd189999, 32'd4119999
    };

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    irpd_in_if  in_ch ();
    irpd_out_if out_ch ();

    ir_pulse_decoder_multitap #(.CODE_BITS(CODE_BITS)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    string keypad_map [10] = '{
        " 0", "1", "abc2", "def3", "ghi4", "jkl5", "mno6", "pqrs7", "tuv8", "wxyz9"
    };

    logic [CFG_W-1:0] thresh [CFG_N];
    logic [31:0]      rx_code  = '0;
    int               rx_bits  = 0;
    bit               tap_live = 1'b0;
    int               tap_key  = 0;
    int               tap_pos  = 0;

    logic [IN_W-1:0] interval_q [$];
    t_out_item       key_event_q [$];

    int cycle       = 0;
    int sent_count  = 0;
    int fault_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int last_digit  = -1;

    initial forever #10 i_clk = ~i_clk;

    function automatic bit take_break();
        if (cycle >= CALM_START && cycle < CALM_END) return 1'b0;
        return $urandom_range(99) < 25;
    endfunction

    function automatic void log_fault(string msg);
        if (fault_count < 10) $display("%s", msg);
        fault_count++;
    endfunction

    function automatic bit hits(logic [IN_W-1:0] v, int w);
        return (IN_W'(thresh[2*w]) < v) && (v < IN_W'(thresh[2*w+1]));
    endfunction

    function automatic logic [7:0] glyph(int k, int t);
        if (k > KEY_LAST_DIGIT || t >= keypad_map[k].len()) return 8'h00;
        return keypad_map[k][t];
    endfunction

    function automatic void decode_interval(logic [IN_W-1:0] v);
        t_out_item ev;
        int k;
        if (hits(v, W_START)) begin
            rx_code = '0;
            rx_bits = 0;
            return;
        end
        if (hits(v, W_ZERO) || hits(v, W_ONE)) begin
            if (rx_bits < CODE_BITS) begin
                if (!hits(v, W_ZERO)) rx_code[CODE_BITS-1-rx_bits] = 1'b1;
                rx_bits++;
            end
            return;
        end
        if (!hits(v, W_END)) return;
        ev = '0;
        ev.frame_code = rx_code;
        k = KEY_UNKNOWN;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (k == KEY_UNKNOWN && rx_code == KEY_CODES[i]) k = i;
        end
        ev.key = 4'(k);
        if (k <= KEY_LAST_DIGIT) begin
            if (tap_live && tap_key == k) begin
                tap_pos = (tap_pos + 1) % keypad_map[k].len();
                ev.show_action = SHOW_REPLACE;
            end else begin
                if (tap_live) begin
                    ev.commit_valid = 1'b1;
                    ev.commit_char  = glyph(tap_key, tap_pos);
                end
                tap_live = 1'b1;
                tap_key  = k;
                tap_pos  = 0;
                ev.show_action = SHOW_NEW;
            end
            ev.show_char = glyph(tap_key, tap_pos);
        end else if (k == KEY_ENTER) begin
            if (tap_live) begin
                ev.commit_valid = 1'b1;
                ev.commit_char  = glyph(tap_key, tap_pos);
                tap_live = 1'b0;
            end else begin
                ev.send_message = 1'b1;
            end
        end else if (k == KEY_MUTE) begin
            ev.erase_last = 1'b1;
        end
        key_event_q.push_back(ev);
    endfunction

    function automatic logic [IN_W-1:0] pick_in(int w);
        logic [IN_W-1:0] lo;
        logic [IN_W-1:0] hi;
        int r;
        lo = IN_W'(thresh[2*w]);
        hi = IN_W'(thresh[2*w+1]);
        if (hi <= lo + 1) return lo;
        r = $urandom_range(9);
        if (r == 0) return lo + 1;
        if (r == 1) return hi - 1;
        return $urandom_range(hi - 1, lo + 1);
    endfunction

    function automatic logic [IN_W-1:0] pick_noise();
        if ($urandom_range(1)) return $urandom();
        return pick_in($urandom_range(W_END, W_START)) + ($urandom_range(1) ? 1 : -1);
    endfunction

    function automatic logic [31:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 40 && last_digit >= 0) return KEY_CODES[last_digit];
        if (r < 70) begin
            last_digit = $urandom_range(KEY_LAST_DIGIT);
            return KEY_CODES[last_digit];
        end
        if (r < 82) return KEY_CODES[KEY_ENTER];
        if (r < 92) return KEY_CODES[KEY_MUTE];
        return $urandom();
    endfunction

    function automatic t_th_set make_set(int s_lo, int s_hi, int z_lo, int z_hi,
                                         int o_lo, int o_hi, int e_lo, int e_hi);
        t_th_set th;
        th[CFG_START_LO] = CFG_W'(s_lo);
        th[CFG_START_HI] = CFG_W'(s_hi);
        th[CFG_ZERO_LO]  = CFG_W'(z_lo);
        th[CFG_ZERO_HI]  = CFG_W'(z_hi);
        th[CFG_ONE_LO]   = CFG_W'(o_lo);
        th[CFG_ONE_HI]   = CFG_W'(o_hi);
        th[CFG_END_LO]   = CFG_W'(e_lo);
        th[CFG_END_HI]   = CFG_W'(e_hi);
        return th;
    endfunction

    function automatic t_th_set spread_windows();
        t_th_set th;
        int order [4];
        int cur;
        int hi;
        order = '{W_ZERO, W_ONE, W_START, W_END};
        cur = $urandom_range(3000);
        foreach (order[j]) begin
            hi = cur + $urandom_range(4000, 2);
            th[2*order[j]]   = CFG_W'(cur);
            th[2*order[j]+1] = CFG_W'(hi);
            cur = ($urandom_range(3) == 0) ? hi - 3 : hi + $urandom_range(2000);
        end
        return th;
    endfunction

    task automatic load_thresholds(t_th_set th);
        for (int i = 0; i < CFG_N; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= th[i];
            thresh[i] = th[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_frames(int budget);
        logic [31:0] code;
        int nbits;
        int r;
        bit b;
        while (interval_q.size() < budget) begin
            if ($urandom_range(99) < 8) interval_q.push_back(pick_noise());
            code = pick_code();
            if ($urandom_range(9) != 0) interval_q.push_back(pick_in(W_START));
            r = $urandom_range(99);
            nbits = CODE_BITS;
            if (r < 8) nbits = $urandom_range(CODE_BITS - 1);
            else if (r < 14) nbits = CODE_BITS + $urandom_range(6, 1);
            for (int i = 0; i < nbits; i++) begin
                b = (i < CODE_BITS) ? code[CODE_BITS-1-i] : 1'($urandom_range(1));
                interval_q.push_back(pick_in(b ? W_ONE : W_ZERO));
                if ($urandom_range(99) < 3) interval_q.push_back(pick_noise());
            end
            interval_q.push_back(pick_in(W_END));
        end
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (interval_q.size() != 0 || in_ch.valid || key_event_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                decode_interval(in_ch.req.interval);
                sent_count++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (interval_q.size() != 0 && !take_break()) begin
                    in_ch.valid        <= 1'b1;
                    in_ch.req.interval <= interval_q.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !take_break();
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.req;
            if (key_event_q.size() == 0) begin
                log_fault($sformatf("unexpected key event: code=%h key=%0d", got.frame_code,
                                    got.key));
            end else begin
                want = key_event_q.pop_front();
                if (got.frame_code !== want.frame_code || got.key !== want.key ||
                    got.commit_valid !== want.commit_valid ||
                    got.commit_char !== want.commit_char ||
                    got.show_action !== want.show_action ||
                    got.show_char !== want.show_char ||
                    got.erase_last !== want.erase_last ||
                    got.send_message !== want.send_message) begin
                    log_fault($sformatf({"key event mismatch: want code=%h key=%0d cv=%b ",
                        "cc=%h sa=%0d sc=%h er=%b sd=%b, got code=%h key=%0d cv=%b ",
                        "cc=%h sa=%0d sc=%h er=%b sd=%b"},
                        want.frame_code, want.key, want.commit_valid, want.commit_char,
                        want.show_action, want.show_char, want.erase_last,
                        want.send_message, got.frame_code, got.key, got.commit_valid,
                        got.commit_char, got.show_action, got.show_char, got.erase_last,
                        got.send_message));
                end
            end
        end
    end

    initial begin
        t_th_set th;
        in_ch.valid    = 1'b0;
        in_ch.req      = '0;
        out_ch.ready   = 1'b0;
        for (int i = 0; i < CFG_N; i++) thresh[i] = CFG_RESET[i];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (EDGE_CASES[i]) interval_q.push_back(EDGE_CASES[i]);
        fill_frames(350);
        settle();

        load_thresholds(make_set(2, 4, 0, 2, 1, 3, 3, 5));
        fill_frames(250);
        settle();

        load_thresholds(make_set(24'hFFFFF8, 24'hFFFFFA, 24'hFFFFF0, 24'hFFFFF2,
                                 24'hFFFFF2, 24'hFFFFF4, 24'hFFFFFD, 24'hFFFFFF));
        fill_frames(250);
        settle();

        load_thresholds('0);
        fill_frames(40);
        settle();

        load_thresholds('1);
        fill_frames(40);
        settle();

        repeat (3) begin
            load_thresholds(spread_windows());
            fill_frames(170);
            settle();
        end

        for (int i = 0; i < CFG_N; i++) th[i] = CFG_RESET[i];
        load_thresholds(th);
        fill_frames(220);
        settle();

        if (key_event_q.size() != 0) begin
            log_fault($sformatf("%0d key events never arrived", key_event_q.size()));
        end
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
